@@ hw/rtl/packet_gap_timestamp_tracker_defines.svh @@
// assertion macros shared by the checker of packet_gap_timestamp_tracker
// no dependencies; pulled in with an include by the checker file
`ifndef PACKET_GAP_TIMESTAMP_TRACKER_DEFINES_SVH
`define PACKET_GAP_TIMESTAMP_TRACKER_DEFINES_SVH

// antecedent holds in this cycle, consequent must hold in the same cycle
`define PGTS_ASSERT_SAME(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("pgts check failed");

// antecedent holds in this cycle, consequent must hold in the next cycle
`define PGTS_ASSERT_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("pgts check failed");

`endif

@@ hw/rtl/pgts_pkg.sv @@
// shared widths, register codes and types of the packet gap timestamp tracker
// no dependencies
package pgts_pkg;

  localparam int COUNTER_BITS_DEF = 16;
  localparam int CNT_IN_W         = 16;
  localparam int SAMPLES_W        = 13;
  localparam int TS_W             = 32;
  localparam int SILENCE_W        = 15;
  localparam int LOST_W           = 32;
  localparam int CFG_DATA_W       = 32;
  localparam int CFG_INDEX_W      = 1;

  localparam logic [SAMPLES_W-1:0] SAMPLES_RESET = 13'd48;
  localparam logic [TS_W-1:0]      ANCHOR_RESET  = 32'd0;
  localparam logic [SILENCE_W-1:0] SILENCE_MAX   = 15'h7fff;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SAMPLES = 1'b0,
    REG_ANCHOR  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [SAMPLES_W-1:0] samples_per_packet;
    logic [TS_W-1:0]      anchor_timestamp;
  } cfg_t;

  typedef struct packed {
    logic [TS_W-1:0]      media_timestamp;
    logic [SILENCE_W-1:0] silence_count;
    logic [LOST_W-1:0]    lost_total;
  } result_t;

endpackage

@@ hw/rtl/pgts_ifs.sv @@
// stream interfaces of the packet gap timestamp tracker: packets in, results out
// depends on pgts_pkg
interface pgts_pkt_if;
  import pgts_pkg::*;

  logic                valid;
  logic                ready;
  logic [CNT_IN_W-1:0] packet_counter;

  modport source (output valid, output packet_counter, input ready);
  modport sink   (input valid, input packet_counter, output ready);
endinterface

interface pgts_res_if;
  import pgts_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [TS_W-1:0]      media_timestamp;
  logic [SILENCE_W-1:0] silence_count;
  logic [LOST_W-1:0]    lost_total;

  modport source (output valid, output media_timestamp, output silence_count,
                  output lost_total, input ready);
  modport sink   (input valid, input media_timestamp, input silence_count,
                  input lost_total, output ready);
endinterface

@@ hw/rtl/pgts_tracker.sv @@
// tracker state (started, high counter, timeline, loss total) and the
// per-packet gap sort, multiply-add and loss update; depends on pgts_pkg
module pgts_tracker #(
  parameter int COUNTER_BITS = pgts_pkg::COUNTER_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  pgts_pkg::cfg_t          cfg,
  input  logic                    fire,
  input  logic [COUNTER_BITS-1:0] counter,
  output pgts_pkg::result_t       result
);
  import pgts_pkg::*;

  logic                    started;
  logic [COUNTER_BITS-1:0] high_counter;
  logic [TS_W-1:0]         timeline;
  logic [LOST_W-1:0]       loss_acc;

  logic                    started_next;
  logic [COUNTER_BITS-1:0] high_counter_next;
  logic [TS_W-1:0]         timeline_next;
  logic [LOST_W-1:0]       loss_acc_next;

  logic [COUNTER_BITS-1:0] delta;
  logic                    late;
  logic [COUNTER_BITS-1:0] slots;
  logic [TS_W-1:0]         slots_w;
  logic [TS_W-1:0]         samples_w;
  logic [TS_W-1:0]         step;
  logic [LOST_W-1:0]       delta_w;
  logic [SILENCE_W-1:0]    silence;

  // signed distance from the expected counter, negative means late or duplicate
  assign delta   = counter - high_counter - COUNTER_BITS'(1);
  assign late    = delta[COUNTER_BITS-1];
  assign slots   = late ? COUNTER_BITS'(1) : (delta + COUNTER_BITS'(1));
  assign delta_w = LOST_W'(delta);

  // timeline step, only the low 32 bits of the product matter
  assign slots_w   = TS_W'(slots);
  assign samples_w = TS_W'(cfg.samples_per_packet);
  assign step      = slots_w * samples_w;

  // next state and result of this packet
  always_comb begin
    started_next      = 1'b1;
    high_counter_next = high_counter;
    timeline_next     = timeline;
    loss_acc_next     = loss_acc;
    silence           = '0;
    if (!started) begin
      high_counter_next = counter;
      timeline_next     = cfg.anchor_timestamp;
    end else if (late) begin
      timeline_next = timeline + step;
    end else begin
      high_counter_next = counter;
      timeline_next     = timeline + step;
      loss_acc_next     = loss_acc + delta_w;
      silence           = (delta_w > LOST_W'(SILENCE_MAX)) ? SILENCE_MAX
                                                           : delta_w[SILENCE_W-1:0];
    end
  end

  assign result.media_timestamp = timeline_next;
  assign result.silence_count   = silence;
  assign result.lost_total      = loss_acc_next;

  // state update on each transfer into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      started      <= 1'b0;
      high_counter <= '0;
      timeline     <= ANCHOR_RESET;
      loss_acc     <= '0;
    end else if (fire) begin
      started      <= started_next;
      high_counter <= high_counter_next;
      timeline     <= timeline_next;
      loss_acc     <= loss_acc_next;
    end
  end

endmodule

@@ hw/rtl/packet_gap_timestamp_tracker.sv @@
// top level of the packet gap timestamp tracker: input register, config
// registers, tracker and result register; depends on pgts_pkg, pgts_ifs, pgts_tracker
//
//   channel  dir  payload                                      transfer
//   pkt      in   packet_counter                               valid & ready
//   res      out  media_timestamp, silence_count, lost_total   valid & ready
//   cfg      in   cfg_index, cfg_data                          cfg_wr_en
//
// one packet per cycle sustained while the result sink keeps up; a result passes
// through the input register, where the gap sort and multiply-add feed the
// result register, and then through the result register. rst is synchronous
// and clears the tracker state and both valid flags; pkt.ready is low while rst
// is high. a stalled result holds the result register, and an empty input
// register still takes one more packet before pkt.ready drops.
module packet_gap_timestamp_tracker #(
  parameter int COUNTER_BITS = pgts_pkg::COUNTER_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  pgts_pkt_if.sink                           pkt,
  pgts_res_if.source                         res,
  input  logic                               cfg_wr_en,
  input  logic [pgts_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [pgts_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import pgts_pkg::*;

  cfg_t                    cfg;
  logic                    in_valid;
  logic [CNT_IN_W-1:0]     in_counter;
  logic                    out_valid;
  result_t                 out_data;
  result_t                 result;
  logic                    out_free;
  logic                    advance;
  logic [31:0]             cnt_wide;
  logic [COUNTER_BITS-1:0] counter;

  // handshake between the two register stages
  assign out_free  = !out_valid || res.ready;
  assign advance   = in_valid && out_free;
  assign pkt.ready = !rst && (!in_valid || advance);

  // counter masked to the configured counter width
  assign cnt_wide = 32'(in_counter);
  assign counter  = cnt_wide[COUNTER_BITS-1:0];

  pgts_tracker #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_tracker (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .fire    (advance),
    .counter (counter),
    .result  (result)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.samples_per_packet <= SAMPLES_RESET;
      cfg.anchor_timestamp   <= ANCHOR_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SAMPLES: cfg.samples_per_packet <= cfg_data[SAMPLES_W-1:0];
        REG_ANCHOR:  cfg.anchor_timestamp   <= cfg_data[TS_W-1:0];
        default: ;
      endcase
    end
  end

  // input register and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pkt.valid && pkt.ready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (pkt.valid && pkt.ready) begin
      in_counter <= pkt.packet_counter;
    end
    if (advance) begin
      out_data <= result;
    end
  end

  assign res.valid           = out_valid;
  assign res.media_timestamp = out_data.media_timestamp;
  assign res.silence_count   = out_data.silence_count;
  assign res.lost_total      = out_data.lost_total;

endmodule

@@ hw/rtl/pgts_checker.sv @@
// port-level checks of packet_gap_timestamp_tracker and the bind that attaches them
// depends on pgts_pkg and packet_gap_timestamp_tracker_defines.svh
`include "packet_gap_timestamp_tracker_defines.svh"

module pgts_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           pkt_valid,
  input logic                           pkt_ready,
  input logic                           res_valid,
  input logic                           res_ready,
  input logic [pgts_pkg::TS_W-1:0]      res_ts,
  input logic [pgts_pkg::SILENCE_W-1:0] res_silence,
  input logic [pgts_pkg::LOST_W-1:0]    res_lost
);
  import pgts_pkg::*;

  // reset empties the result register
  `PGTS_ASSERT_NEXT(a_reset_clears, clk, 1'b0, rst, !res_valid)

  // with no result waiting, the block always takes a packet
  `PGTS_ASSERT_SAME(a_ready_when_empty, clk, rst, !res_valid, pkt_ready)

  // a packet reaches the output from the input register when the sink is ready
  `PGTS_ASSERT_NEXT(a_latency, clk, rst, (pkt_valid && pkt_ready) ##1 res_ready, res_valid)

  // a stalled result stays put
  `PGTS_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready,
                    res_valid && $stable(res_ts) && $stable(res_silence) && $stable(res_lost))

endmodule

bind packet_gap_timestamp_tracker pgts_checker u_pgts_checker (
  .clk         (clk),
  .rst         (rst),
  .pkt_valid   (pkt.valid),
  .pkt_ready   (pkt.ready),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .res_ts      (res.media_timestamp),
  .res_silence (res.silence_count),
  .res_lost    (res.lost_total)
);
